>>> hdl/vlrs_pkg.sv
package vlrs_pkg;

	// default geometry
	localparam int STACK_BYTES_DEF = 1024;
	localparam int LEN_BYTES_DEF   = 2;
	localparam int MAX_ELEM        = 64;

	// field widths
	localparam int OP_W   = 3;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
	localparam logic [OP_W-1:0] OP_POP   = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
	localparam logic [OP_W-1:0] OP_CHECK = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_TRAIL,
		ST_TRD_ADDR,
		ST_TRD_DATA,
		ST_CALC,
		ST_CALC2,
		ST_DATA,
		ST_DTAIL
	} state_t;

endpackage

>>> hdl/variable_length_record_stack_top.sv
// channel   | handshake              | fields
// ----------+------------------------+--------------------------------------------------
// command   | start, busy            | op, data_in, elem_len, first, last
// result    | strobe (one cycle)     | data_out, byte_valid, run_last, ok, empty_res,
//           |                        | full_res
//
// a command is taken when start is high and busy is low; busy holds until its last beat.
// a push byte answers from the exec state; a committing last also writes the LEN_BYTES trailer,
// one byte a cycle. pop/peek of n bytes, or of none, first walk the trailer
// (address then data per byte), then return one byte a cycle through the single ram port.
// check, clear, spare codes and reads of an empty stack answer straight from the exec state.
// reset clears pointers and control only, not the byte store; results cannot be stalled.
module variable_length_record_stack_top
	import vlrs_pkg::*;
#(
	parameter int STACK_BYTES = STACK_BYTES_DEF,
	parameter int LEN_BYTES   = LEN_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [OP_W-1:0]   op,
	input  logic [BYTE_W-1:0] data_in,
	input  logic [LEN_W-1:0]  elem_len,
	input  logic              first,
	input  logic              last,
	output logic              strobe,
	output logic [BYTE_W-1:0] data_out,
	output logic              byte_valid,
	output logic              run_last,
	output logic              ok,
	output logic              empty_res,
	output logic              full_res
);

	localparam int TOP_W  = $clog2(STACK_BYTES + 1);
	localparam int ADDR_W = $clog2(STACK_BYTES);
	localparam int SUM_W  = ((TOP_W > 8) ? TOP_W : 8) + 1;
	localparam int IDX_W  = (LEN_BYTES > 1) ? $clog2(LEN_BYTES) : 1;

	state_t state_q, state_d;

	// latched command
	logic [OP_W-1:0]   op_q;
	logic [BYTE_W-1:0] din_q;
	logic [LEN_W-1:0]  req_q;
	logic              first_q;
	logic              last_q;

	// stack and push state
	logic [TOP_W-1:0]  top_q;
	logic              active_q;
	logic              rejected_q;
	logic [LEN_W-1:0]  count_q;
	logic [LEN_W-1:0]  limit_q;
	logic [LEN_W-1:0]  rec_len_q;
	logic              push_ok_q;

	// read walk
	logic [IDX_W-1:0]  idx_q;
	logic [TOP_W-1:0]  t_q;
	logic [BYTE_W-1:0] low_q;
	logic              big_q;
	logic [TOP_W-1:0]  stored_q;
	logic [TOP_W-1:0]  start_q;
	logic [LEN_W-1:0]  n_q;
	logic [LEN_W-1:0]  k_q;
	logic              pend_q;
	logic              pend_last_q;

	// result register
	logic              strobe_q;
	logic [BYTE_W-1:0] data_q;
	logic              valid_q;
	logic              rlast_q;
	logic              rok_q;

	// ram port
	logic              mem_we;
	logic [SUM_W-1:0]  addr_sum;
	logic [BYTE_W-1:0] mem_wdata;
	logic [BYTE_W-1:0] mem_rdata;

	// per-state control
	logic              em;
	logic              em_ok;

	// push decode, with a first byte reopening the record
	logic              is_empty;
	logic              room_fail;
	logic              p_act;
	logic              p_rej;
	logic [LEN_W-1:0]  p_cnt;
	logic [LEN_W-1:0]  p_lim;
	logic              p_live;
	logic              p_wr;
	logic [LEN_W-1:0]  p_cnt_n;
	logic              commit;
	logic [TOP_W-1:0]  start_calc;
	logic [SUM_W-1:0]  n_sel;
	logic [LEN_W-1:0]  n_calc;

	assign is_empty  = top_q < TOP_W'(LEN_BYTES);
	assign room_fail = (SUM_W'(top_q) + SUM_W'(req_q) + SUM_W'(LEN_BYTES))
		> SUM_W'(STACK_BYTES);

	assign p_act   = first_q ? 1'b1 : active_q;
	assign p_rej   = first_q ? ((req_q > LEN_W'(MAX_ELEM)) || room_fail) : rejected_q;
	assign p_cnt   = first_q ? '0 : count_q;
	assign p_lim   = first_q ? req_q : limit_q;
	assign p_live  = p_act && !p_rej;
	assign p_wr    = p_live && (p_cnt < p_lim);
	assign p_cnt_n = p_cnt + LEN_W'(p_wr);
	assign commit  = last_q && p_live;

	// record start and byte count once the trailer is known
	assign start_calc = t_q - stored_q;
	always_comb begin
		n_sel = (SUM_W'(req_q) < SUM_W'(stored_q)) ? SUM_W'(req_q) : SUM_W'(stored_q);
		if (n_sel > SUM_W'(MAX_ELEM)) begin
			n_sel = SUM_W'(MAX_ELEM);
		end
		n_calc = n_sel[LEN_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op_q)
					OP_PUSH:         state_d = commit ? ST_TRAIL : ST_IDLE;
					OP_POP, OP_PEEK: state_d = is_empty ? ST_IDLE : ST_TRD_ADDR;
					default:         state_d = ST_IDLE;
				endcase
			end
			ST_TRAIL: begin
				if (idx_q == IDX_W'(LEN_BYTES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_TRD_ADDR: state_d = ST_TRD_DATA;
			ST_TRD_DATA: state_d = (idx_q == '0) ? ST_CALC : ST_TRD_ADDR;
			ST_CALC:     state_d = ST_CALC2;
			ST_CALC2:    state_d = (n_calc == '0) ? ST_IDLE : ST_DATA;
			ST_DATA: begin
				if (k_q + LEN_W'(1) == n_q) begin
					state_d = ST_DTAIL;
				end
			end
			ST_DTAIL:    state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// state outputs: ram port and single results
	always_comb begin
		busy      = state_q != ST_IDLE;
		mem_we    = 1'b0;
		addr_sum  = SUM_W'(top_q);
		mem_wdata = din_q;
		em        = 1'b0;
		em_ok     = 1'b0;
		case (state_q)
			ST_EXEC: begin
				em = 1'b1;
				case (op_q)
					OP_PUSH: begin
						mem_we   = p_wr;
						addr_sum = SUM_W'(top_q) + SUM_W'(p_cnt);
						em       = !commit;
						em_ok    = p_wr;
					end
					OP_POP, OP_PEEK: begin
						em    = is_empty;
						em_ok = 1'b0;
					end
					OP_CHECK, OP_CLEAR: em_ok = 1'b1;
					default:            em_ok = 1'b0;
				endcase
			end
			ST_TRAIL: begin
				mem_we    = 1'b1;
				addr_sum  = SUM_W'(top_q) + SUM_W'(rec_len_q) + SUM_W'(idx_q);
				mem_wdata = (idx_q == '0) ? BYTE_W'(rec_len_q) : '0;
				em        = idx_q == IDX_W'(LEN_BYTES - 1);
				em_ok     = push_ok_q;
			end
			ST_TRD_ADDR: addr_sum = SUM_W'(t_q) + SUM_W'(idx_q);
			ST_CALC2: begin
				em    = n_calc == '0;
				em_ok = 1'b1;
			end
			ST_DATA:     addr_sum = SUM_W'(start_q) + SUM_W'(k_q);
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// byte store
	vlrs_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STACK_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (addr_sum[ADDR_W-1:0]),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// stack pointer, push state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q      <= '0;
			active_q   <= 1'b0;
			rejected_q <= 1'b0;
			count_q    <= '0;
			limit_q    <= '0;
			pend_q     <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			pend_q   <= state_q == ST_DATA;
			strobe_q <= em || pend_q;
			case (state_q)
				ST_EXEC: begin
					if (op_q == OP_PUSH) begin
						active_q   <= last_q ? 1'b0 : p_act;
						rejected_q <= last_q ? 1'b0 : p_rej;
						count_q    <= last_q ? '0 : p_cnt_n;
						limit_q    <= last_q ? '0 : p_lim;
					end else if (op_q <= OP_CLEAR) begin
						active_q   <= 1'b0;
						rejected_q <= 1'b0;
						count_q    <= '0;
						limit_q    <= '0;
					end
					if (op_q == OP_CLEAR) begin
						top_q <= '0;
					end
				end
				ST_TRAIL: begin
					if (idx_q == IDX_W'(LEN_BYTES - 1)) begin
						top_q <= top_q + TOP_W'(rec_len_q) + TOP_W'(LEN_BYTES);
					end
				end
				ST_CALC2: begin
					if (op_q == OP_POP) begin
						top_q <= start_calc;
					end
				end
				default: begin
					top_q <= top_q;
				end
			endcase
		end
	end

	// command capture and read walk datapath
	always_ff @(posedge clk) begin
		pend_last_q <= (state_q == ST_DATA) && (k_q + LEN_W'(1) == n_q);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_q    <= op;
					din_q   <= data_in;
					req_q   <= elem_len;
					first_q <= first;
					last_q  <= last;
				end
			end
			ST_EXEC: begin
				push_ok_q <= p_wr;
				rec_len_q <= p_cnt_n;
				idx_q     <= (op_q == OP_PUSH) ? '0 : IDX_W'(LEN_BYTES - 1);
				t_q       <= top_q - TOP_W'(LEN_BYTES);
				big_q     <= 1'b0;
			end
			ST_TRAIL: idx_q <= idx_q + IDX_W'(1);
			ST_TRD_DATA: begin
				if (idx_q == '0) begin
					low_q <= mem_rdata;
				end else begin
					big_q <= big_q || (mem_rdata != '0);
					idx_q <= idx_q - IDX_W'(1);
				end
			end
			ST_CALC: begin
				stored_q <= (big_q || (SUM_W'(low_q) > SUM_W'(t_q))) ? t_q : TOP_W'(low_q);
			end
			ST_CALC2: begin
				start_q <= start_calc;
				n_q     <= n_calc;
				k_q     <= '0;
			end
			ST_DATA: k_q <= k_q + LEN_W'(1);
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	// result beat register
	always_ff @(posedge clk) begin
		data_q  <= pend_q ? mem_rdata : '0;
		valid_q <= pend_q;
		rlast_q <= pend_q ? pend_last_q : 1'b1;
		rok_q   <= pend_q ? 1'b1 : em_ok;
	end

	assign strobe     = strobe_q;
	assign data_out   = data_q;
	assign byte_valid = valid_q;
	assign run_last   = rlast_q;
	assign ok         = rok_q;
	assign empty_res  = is_empty;
	assign full_res   = room_fail;

endmodule

>>> hdl/vlrs_ram.sv
module vlrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> hdl/vlrs_checker.sv
module vlrs_checker
	import vlrs_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic [OP_W-1:0] op,
	input logic            strobe,
	input logic            byte_valid,
	input logic            run_last,
	input logic            ok
);

	// an accepted command always leaves the block busy in the cycle after
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after a command beat");

	// a record byte is only returned by a successful read
	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && byte_valid) |-> ok)
		else $error("record byte returned without ok");

	// a run that is not finished keeps the block busy
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !run_last) |-> busy)
		else $error("block idle in the middle of a result run");

	// status check answers with a single successful beat, registered after the exec state
	a_check_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op == OP_CHECK)) |=> ##1 (strobe && run_last && ok && !byte_valid))
		else $error("status check result missing or malformed");

endmodule

bind variable_length_record_stack_top vlrs_checker u_vlrs_checker (.*);
